[hdl/ttm_pkg.sv]
`default_nettype none

package ttm_pkg;

	localparam int NUM_SLOTS = 16;
	localparam int SLOT_W    = $clog2(NUM_SLOTS);

	// Request codes carried in the input tuser field.
	localparam logic [2:0] REQ_ADD     = 3'd0;
	localparam logic [2:0] REQ_CANCEL  = 3'd1;
	localparam logic [2:0] REQ_REFRESH = 3'd2;
	localparam logic [2:0] REQ_RESET   = 3'd3;
	localparam logic [2:0] REQ_NEXT    = 3'd4;
	localparam logic [2:0] REQ_EXPIRE  = 3'd5;

	// Result status codes.
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_INACTIVE = 2'd1;
	localparam logic [1:0] STAT_FULL     = 2'd2;

	localparam logic [31:0] DEFAULT_WINDOW_MS = 32'd3600000;

	localparam int IN_DATA_W  = 104;
	localparam int OUT_DATA_W = 72;

endpackage

`default_nettype wire

[hdl/timer_table_manager_unit.sv]
// Timer table manager: one request in flight at a time, s_tready is high only when idle.
// Cancel and unused codes go from S_START to S_EMIT; refresh and reset pass S_READ, reset may also pass S_CALC.
// Add and next wait make one pass over all 16 deadline entries, one per cycle.
// Expire makes one such pass, plus one more per fired timer, since each fired timer costs one
// more pass of the single subtractor over the deadline memory.
// Asynchronous reset clears the active and recurring flags, the front notice and the previous time at once.
`default_nettype none

module timer_table_manager_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output      logic                            s_tready,
	// slot[3:0], period_ms[35:4], recurring[36], from_now[37], now_ms[101:38], zero pad
	input  wire logic [ttm_pkg::IN_DATA_W-1:0]   s_tdata,
	// req_type[2:0]
	input  wire logic [2:0]                      s_tuser,
	output      logic                            m_tvalid,
	input  wire logic                            m_tready,
	// status[1:0], result_slot[5:2], wait_ms[69:6], at_front[70], any_active[71]
	output      logic [ttm_pkg::OUT_DATA_W-1:0]  m_tdata,
	// fired[0]
	output      logic                            m_tuser,
	output      logic                            m_tlast,
	input  wire logic                            cfg_we,
	input  wire logic [31:0]                     cfg_wdata
);

	localparam int SW = ttm_pkg::SLOT_W;
	localparam int NS = ttm_pkg::NUM_SLOTS;
	localparam logic [SW-1:0] LAST_SLOT = SW'(NS - 1);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_START = 9'b000000010,
		S_READ  = 9'b000000100,
		S_CALC  = 9'b000001000,
		S_ROLL  = 9'b000010000,
		S_SCAN  = 9'b000100000,
		S_PICK  = 9'b001000000,
		S_FIRE  = 9'b010000000,
		S_EMIT  = 9'b100000000
	} state_t;

	state_t state_q;

	// Latched request
	logic [2:0]    req_q;
	logic [SW-1:0] slot_q;
	logic [31:0]   period_q;
	logic          rec_in_q;
	logic          fnow_q;
	logic [63:0]   now_q;

	// Table flags and global state
	logic [NS-1:0] active_q;
	logic [NS-1:0] slot_rec_q;
	logic          pending_q;
	logic [63:0]   prev_q;
	logic [31:0]   window_q;

	// Deadline and period memories
	logic [63:0] dl_mem [NS];
	logic [31:0] per_mem [NS];
	logic [63:0] dl_rd_q;
	logic [31:0] per_rd_q;
	logic [SW-1:0] rd_addr;
	logic [SW-1:0] wr_addr;
	logic          dl_we;
	logic          per_we;
	logic [31:0]   per_wd;

	// Scan sequencer
	logic [SW-1:0] scan_idx_q;
	logic          scan_run_q;
	logic          vld_s1;
	logic [SW-1:0] idx_s1;

	// Working registers
	logic [63:0]   ref_q;
	logic [63:0]   tmp_q;
	logic          have_q;
	logic          found_q;
	logic          roll_q;
	logic          sel_q;
	logic [SW-1:0] fslot_q;
	logic [SW-1:0] best_q;
	logic [31:0]   bestp_q;
	logic [NS-1:0] due_q;
	logic [NS-1:0] taken_q;
	logic          any_after_q;
	logic [1:0]    st_q;

	// Output register
	logic          m_tvalid_q;
	logic [1:0]    o_status_q;
	logic [SW-1:0] o_slot_q;
	logic [63:0]   o_wait_q;
	logic          o_front_q;
	logic          o_fired_q;
	logic          o_last_q;
	logic          o_any_q;

	// Shared add/subtract unit; compares come from its borrow and zero outputs.
	logic [63:0] alu_a;
	logic [63:0] alu_b;
	logic        alu_sub;
	logic [64:0] alu_res;
	logic        alu_borrow;
	logic        alu_zero;

	logic [SW-1:0] free_slot;
	logic          all_active;
	logic          out_free;
	logic          slot_valid;
	logic          reset_keep;
	logic [NS-1:0] best_mask;
	logic [NS-1:0] rem_after;

	assign alu_res    = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
	                            : ({1'b0, alu_a} + {1'b0, alu_b});
	assign alu_borrow = alu_res[64];
	assign alu_zero   = (alu_res[63:0] == 64'd0);

	assign all_active = &active_q;
	assign out_free   = !m_tvalid_q || m_tready;
	assign slot_valid = active_q[slot_q];
	assign reset_keep = (period_q == per_rd_q) && !fnow_q;
	assign best_mask  = NS'(1) << best_q;
	assign rem_after  = due_q & ~taken_q & ~best_mask;

	always_comb begin
		free_slot = '0;
		for (int i = NS - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_slot = SW'(i);
			end
		end
	end

	// Operand selection and memory control
	always_comb begin
		alu_a   = now_q;
		alu_b   = 64'd0;
		alu_sub = 1'b0;
		rd_addr = slot_q;
		wr_addr = slot_q;
		dl_we   = 1'b0;
		per_we  = 1'b0;
		per_wd  = period_q;
		unique case (state_q)
			S_START: begin
				if (req_q == ttm_pkg::REQ_ADD) begin
					alu_b   = {32'd0, period_q};
					wr_addr = free_slot;
					dl_we   = !all_active;
					per_we  = !all_active;
				end else if (req_q == ttm_pkg::REQ_EXPIRE) begin
					alu_a   = prev_q;
					alu_b   = now_q;
					alu_sub = 1'b1;
				end
			end
			S_ROLL: begin
				alu_a   = {32'd0, window_q};
				alu_b   = tmp_q;
				alu_sub = 1'b1;
			end
			S_READ: begin
				if (req_q == ttm_pkg::REQ_REFRESH) begin
					alu_b = {32'd0, per_rd_q};
					dl_we = 1'b1;
				end else if (fnow_q) begin
					alu_b  = {32'd0, period_q};
					dl_we  = !reset_keep && slot_valid;
					per_we = !reset_keep && slot_valid;
				end else begin
					alu_a   = dl_rd_q;
					alu_b   = {32'd0, per_rd_q};
					alu_sub = 1'b1;
				end
			end
			S_CALC: begin
				alu_a  = tmp_q;
				alu_b  = {32'd0, period_q};
				dl_we  = 1'b1;
				per_we = 1'b1;
			end
			S_SCAN: begin
				rd_addr = scan_idx_q;
				alu_sub = 1'b1;
				if (req_q == ttm_pkg::REQ_EXPIRE && !sel_q) begin
					alu_a = now_q;
					alu_b = dl_rd_q;
				end else begin
					alu_a = dl_rd_q;
					alu_b = ref_q;
				end
			end
			S_FIRE: begin
				alu_b   = {32'd0, bestp_q};
				wr_addr = best_q;
				dl_we   = out_free && slot_rec_q[best_q];
			end
			S_EMIT: begin
				alu_a   = ref_q;
				alu_b   = now_q;
				alu_sub = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (dl_we) begin
			dl_mem[wr_addr] <= alu_res[63:0];
		end
		dl_rd_q <= dl_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (per_we) begin
			per_mem[wr_addr] <= per_wd;
		end
		per_rd_q <= per_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			req_q       <= '0;
			slot_q      <= '0;
			period_q    <= '0;
			rec_in_q    <= 1'b0;
			fnow_q      <= 1'b0;
			now_q       <= '0;
			active_q    <= '0;
			slot_rec_q  <= '0;
			pending_q   <= 1'b0;
			prev_q      <= '0;
			window_q    <= ttm_pkg::DEFAULT_WINDOW_MS;
			scan_idx_q  <= '0;
			scan_run_q  <= 1'b0;
			vld_s1      <= 1'b0;
			idx_s1      <= '0;
			ref_q       <= '0;
			tmp_q       <= '0;
			have_q      <= 1'b0;
			found_q     <= 1'b0;
			roll_q      <= 1'b0;
			sel_q       <= 1'b0;
			fslot_q     <= '0;
			best_q      <= '0;
			bestp_q     <= '0;
			due_q       <= '0;
			taken_q     <= '0;
			any_after_q <= 1'b0;
			st_q        <= ttm_pkg::STAT_OK;
			m_tvalid_q  <= 1'b0;
			o_status_q  <= '0;
			o_slot_q    <= '0;
			o_wait_q    <= '0;
			o_front_q   <= 1'b0;
			o_fired_q   <= 1'b0;
			o_last_q    <= 1'b0;
			o_any_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				window_q <= cfg_wdata;
			end
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						req_q    <= s_tuser;
						slot_q   <= s_tdata[3:0];
						period_q <= s_tdata[35:4];
						rec_in_q <= s_tdata[36];
						fnow_q   <= s_tdata[37];
						now_q    <= s_tdata[101:38];
						state_q  <= S_START;
					end
				end

				S_START: begin
					scan_idx_q <= '0;
					scan_run_q <= 1'b1;
					vld_s1     <= 1'b0;
					have_q     <= 1'b0;
					found_q    <= 1'b0;
					sel_q      <= 1'b0;
					taken_q    <= '0;
					st_q       <= ttm_pkg::STAT_OK;
					unique case (req_q)
						ttm_pkg::REQ_ADD: begin
							if (all_active) begin
								st_q    <= ttm_pkg::STAT_FULL;
								state_q <= S_EMIT;
							end else begin
								active_q[free_slot]   <= 1'b1;
								slot_rec_q[free_slot] <= rec_in_q;
								ref_q                 <= alu_res[63:0];
								fslot_q               <= free_slot;
								state_q               <= S_SCAN;
							end
						end
						ttm_pkg::REQ_CANCEL: begin
							if (slot_valid) begin
								active_q[slot_q] <= 1'b0;
							end else begin
								st_q <= ttm_pkg::STAT_INACTIVE;
							end
							state_q <= S_EMIT;
						end
						ttm_pkg::REQ_REFRESH: begin
							if (slot_valid) begin
								state_q <= S_READ;
							end else begin
								st_q    <= ttm_pkg::STAT_INACTIVE;
								state_q <= S_EMIT;
							end
						end
						ttm_pkg::REQ_RESET: begin
							state_q <= S_READ;
						end
						ttm_pkg::REQ_NEXT: begin
							pending_q <= 1'b0;
							state_q   <= S_SCAN;
						end
						ttm_pkg::REQ_EXPIRE: begin
							if (active_q == '0) begin
								scan_run_q <= 1'b0;
								state_q    <= S_EMIT;
							end else begin
								prev_q <= now_q;
								// Time went backward only if previous time is strictly larger.
								if (!alu_borrow && !alu_zero) begin
									tmp_q      <= alu_res[63:0];
									scan_run_q <= 1'b0;
									state_q    <= S_ROLL;
								end else begin
									roll_q  <= 1'b0;
									state_q <= S_SCAN;
								end
							end
						end
						default: begin
							scan_run_q <= 1'b0;
							state_q    <= S_EMIT;
						end
					endcase
				end

				S_ROLL: begin
					roll_q     <= alu_borrow;
					scan_idx_q <= '0;
					scan_run_q <= 1'b1;
					state_q    <= S_SCAN;
				end

				S_READ: begin
					if (req_q == ttm_pkg::REQ_REFRESH) begin
						state_q <= S_EMIT;
					end else if (reset_keep) begin
						state_q <= S_EMIT;
					end else if (!slot_valid) begin
						st_q    <= ttm_pkg::STAT_INACTIVE;
						state_q <= S_EMIT;
					end else if (fnow_q) begin
						state_q <= S_EMIT;
					end else begin
						tmp_q   <= alu_res[63:0];
						state_q <= S_CALC;
					end
				end

				S_CALC: begin
					state_q <= S_EMIT;
				end

				S_SCAN: begin
					if (scan_run_q) begin
						vld_s1 <= 1'b1;
						idx_s1 <= scan_idx_q;
						if (scan_idx_q == LAST_SLOT) begin
							scan_run_q <= 1'b0;
						end else begin
							scan_idx_q <= scan_idx_q + 1'b1;
						end
					end else begin
						vld_s1 <= 1'b0;
					end
					if (vld_s1) begin
						if (req_q == ttm_pkg::REQ_ADD) begin
							if (active_q[idx_s1] && idx_s1 != fslot_q &&
							    (alu_borrow || (alu_zero && idx_s1 < fslot_q))) begin
								found_q <= 1'b1;
							end
						end else if (req_q == ttm_pkg::REQ_NEXT) begin
							if (active_q[idx_s1] && (!have_q || alu_borrow)) begin
								ref_q  <= dl_rd_q;
								have_q <= 1'b1;
							end
						end else if (!sel_q) begin
							due_q[idx_s1] <= active_q[idx_s1] && (roll_q || !alu_borrow);
						end else begin
							// Strict compare keeps the lower slot on equal deadlines.
							if (due_q[idx_s1] && !taken_q[idx_s1] && (!have_q || alu_borrow)) begin
								ref_q   <= dl_rd_q;
								best_q  <= idx_s1;
								bestp_q <= per_rd_q;
								have_q  <= 1'b1;
							end
						end
						if (idx_s1 == LAST_SLOT) begin
							if (req_q == ttm_pkg::REQ_EXPIRE) begin
								state_q <= sel_q ? S_FIRE : S_PICK;
							end else begin
								state_q <= S_EMIT;
							end
						end
					end
				end

				S_PICK: begin
					any_after_q <= |(active_q & ~(due_q & ~slot_rec_q));
					if ((due_q & ~taken_q) == '0) begin
						state_q <= S_EMIT;
					end else begin
						sel_q      <= 1'b1;
						have_q     <= 1'b0;
						scan_idx_q <= '0;
						scan_run_q <= 1'b1;
						vld_s1     <= 1'b0;
						state_q    <= S_SCAN;
					end
				end

				S_FIRE: begin
					if (out_free) begin
						m_tvalid_q      <= 1'b1;
						o_status_q      <= ttm_pkg::STAT_OK;
						o_slot_q        <= best_q;
						o_wait_q        <= '0;
						o_front_q       <= 1'b0;
						o_fired_q       <= 1'b1;
						o_last_q        <= (rem_after == '0);
						o_any_q         <= any_after_q;
						taken_q[best_q] <= 1'b1;
						if (!slot_rec_q[best_q]) begin
							active_q[best_q] <= 1'b0;
						end
						state_q <= (rem_after == '0) ? S_IDLE : S_PICK;
					end
				end

				S_EMIT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						o_status_q <= st_q;
						o_slot_q   <= '0;
						o_wait_q   <= '0;
						o_front_q  <= 1'b0;
						o_fired_q  <= 1'b0;
						o_last_q   <= 1'b1;
						o_any_q    <= |active_q;
						if (req_q == ttm_pkg::REQ_ADD && st_q == ttm_pkg::STAT_OK) begin
							o_slot_q <= fslot_q;
							if (!found_q && !pending_q) begin
								o_front_q <= 1'b1;
								pending_q <= 1'b1;
							end
						end
						if (req_q == ttm_pkg::REQ_NEXT) begin
							if (!have_q) begin
								o_wait_q <= '1;
							end else if (!alu_borrow && !alu_zero) begin
								o_wait_q <= alu_res[63:0];
							end
						end
						state_q <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {o_any_q, o_front_q, o_wait_q, o_slot_q, o_status_q};
	assign m_tuser  = o_fired_q;
	assign m_tlast  = o_last_q;

endmodule

`default_nettype wire
